// File: rtl/assert_macros.svh
// Assertion macros included by the integrator core to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/sti_pkg.sv
// Constants and codes of the spectral tristimulus integrator.
package sti_pkg;

  localparam int OUT_W   = 40;
  localparam int ACC_W   = 88;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_CNT_W = $clog2(ACC_W);
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};
  localparam logic [MUL_B_W-1:0] REL_SCALE = 24'd6553600;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_FACTOR  = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FEW    = 2'd1;
  localparam logic [1:0] STATUS_ZERO_Y = 2'd2;

endpackage

// File: rtl/spectral_tristimulus_integrator_core.sv
// One beat is taken at a time. A sample in the window forms its three products and, if an
// earlier one was kept and the wavelength rose, an area step per channel; a final beat then
// scales each integral (absolute) or scales it and divides by the Y integral (relative),
// using the shared 32 x 24 multiplier and bit-serial 88-step divider. The result register
// frees the input side once loaded; while an earlier result waits there, the new one is
// held. Synchronous reset clears the running integrals and loads the register defaults.
`include "assert_macros.svh"

module spectral_tristimulus_integrator_core
  import sti_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // wavelength, spectral_value, match_x, match_y, match_z
  input  logic [79:0]           s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tristim_x, tristim_y, tristim_z
  output logic [119:0]          m_tdata,
  // status
  output logic [1:0]            m_tuser,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW        = 2 * SAMPLE_BITS;
  localparam int ABS_SHIFT = 2 * SAMPLE_BITS - 5;

  typedef enum logic [3:0] {
    IDLE, PROD, SEG_LO, SEG_HI, SEG_ADD, UPDATE,
    FINISH, RES_LO, RES_HI, RES_DIV, RES_STORE, OUTPUT
  } state_t;

  state_t state;

  logic [15:0]            window_low;
  logic [15:0]            window_high;
  logic                   absolute_mode;
  logic [23:0]            absolute_factor;

  logic [15:0]            wl;
  logic [SAMPLE_BITS-1:0] val;
  logic [SAMPLE_BITS-1:0] match [3];
  logic                   final_flag;

  logic [15:0]            prev_wl;
  logic [PW-1:0]          prev_prod [3];
  logic [PW-1:0]          cur_prod [3];
  logic [1:0]             kcnt;
  logic [63:0]            integ [3];
  logic [OUT_W-1:0]       res [3];
  logic [1:0]             status;

  logic [1:0]             ch;
  logic [DIV_CNT_W-1:0]   dcnt;
  logic [ACC_W-1:0]       acc;
  logic [63:0]            rem;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     mul_p;
  logic [PW:0]            seg_sum;
  logic [63:0]            sum64;
  logic [15:0]            dw;
  logic [64:0]            div_sh;
  logic                   div_ge;
  logic [64:0]            integ_add;
  logic [ACC_W-1:0]       res_shift;
  logic [OUT_W-1:0]       res_sat;
  logic                   in_window;

  assign s_tready  = (state == IDLE);
  assign in_window = (s_tdata[15:0] >= window_low) && (s_tdata[15:0] <= window_high);

  assign seg_sum = {1'b0, prev_prod[ch]} + {1'b0, cur_prod[ch]};
  assign sum64   = 64'(seg_sum);
  assign dw      = wl - prev_wl;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      PROD: begin
        mul_a = MUL_A_W'(val);
        mul_b = MUL_B_W'(match[ch]);
      end
      SEG_LO: begin
        mul_a = sum64[31:0];
        mul_b = MUL_B_W'(dw);
      end
      SEG_HI: begin
        mul_a = sum64[63:32];
        mul_b = MUL_B_W'(dw);
      end
      RES_LO: begin
        mul_a = integ[ch][31:0];
        mul_b = absolute_mode ? absolute_factor : REL_SCALE;
      end
      RES_HI: begin
        mul_a = integ[ch][63:32];
        mul_b = absolute_mode ? absolute_factor : REL_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  assign div_sh = {rem, acc[ACC_W-1]};
  assign div_ge = (div_sh >= {1'b0, integ[1]});

  assign integ_add = {1'b0, integ[ch]} + {1'b0, acc[63:0]};

  assign res_shift = absolute_mode ? (acc >> ABS_SHIFT) : acc;
  assign res_sat   = (|res_shift[ACC_W-1:OUT_W]) ? OUT_MAX : res_shift[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      window_low      <= 16'd0;
      window_high     <= 16'hFFFF;
      absolute_mode   <= 1'b0;
      absolute_factor <= 24'd174848;
      kcnt            <= 2'd0;
      ch              <= 2'd0;
      dcnt            <= '0;
      m_tvalid        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        integ[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_LOW:  window_low      <= cfg_data[15:0];
          CFG_WINDOW_HIGH: window_high     <= cfg_data[15:0];
          CFG_ABS_MODE:    absolute_mode   <= cfg_data[0];
          CFG_ABS_FACTOR:  absolute_factor <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != OUTPUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            wl         <= s_tdata[15:0];
            val        <= SAMPLE_BITS'(s_tdata[31:16]);
            match[0]   <= SAMPLE_BITS'(s_tdata[47:32]);
            match[1]   <= SAMPLE_BITS'(s_tdata[63:48]);
            match[2]   <= SAMPLE_BITS'(s_tdata[79:64]);
            final_flag <= s_tlast;
            ch         <= 2'd0;
            if (in_window) begin
              state <= PROD;
            end else if (s_tlast) begin
              state <= FINISH;
            end
          end
        end
        PROD: begin
          cur_prod[ch] <= mul_p[PW-1:0];
          if (ch == 2'd2) begin
            ch <= 2'd0;
            if (kcnt != 2'd0 && wl > prev_wl) begin
              state <= SEG_LO;
            end else begin
              state <= UPDATE;
            end
          end else begin
            ch <= ch + 2'd1;
          end
        end
        SEG_LO: begin
          acc   <= ACC_W'(mul_p);
          state <= SEG_HI;
        end
        SEG_HI: begin
          acc   <= acc + {mul_p, 32'b0};
          state <= SEG_ADD;
        end
        SEG_ADD: begin
          if ((|acc[ACC_W-1:64]) || integ_add[64]) begin
            integ[ch] <= '1;
          end else begin
            integ[ch] <= integ_add[63:0];
          end
          if (ch == 2'd2) begin
            ch    <= 2'd0;
            state <= UPDATE;
          end else begin
            ch    <= ch + 2'd1;
            state <= SEG_LO;
          end
        end
        UPDATE: begin
          for (int i = 0; i < 3; i++) begin
            prev_prod[i] <= cur_prod[i];
          end
          prev_wl <= wl;
          if (kcnt != 2'd2) begin
            kcnt <= kcnt + 2'd1;
          end
          state <= final_flag ? FINISH : IDLE;
        end
        FINISH: begin
          ch <= 2'd0;
          for (int i = 0; i < 3; i++) begin
            res[i] <= '0;
          end
          if (kcnt != 2'd2) begin
            status <= STATUS_FEW;
            state  <= OUTPUT;
          end else if (integ[1] == 64'd0) begin
            status <= STATUS_ZERO_Y;
            state  <= OUTPUT;
          end else begin
            status <= STATUS_OK;
            state  <= RES_LO;
          end
        end
        RES_LO: begin
          acc   <= ACC_W'(mul_p);
          state <= RES_HI;
        end
        RES_HI: begin
          acc  <= acc + {mul_p, 32'b0};
          rem  <= '0;
          dcnt <= '0;
          state <= absolute_mode ? RES_STORE : RES_DIV;
        end
        RES_DIV: begin
          rem  <= div_ge ? 64'(div_sh - {1'b0, integ[1]}) : div_sh[63:0];
          acc  <= {acc[ACC_W-2:0], div_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DIV_CNT_W'(ACC_W - 1)) begin
            state <= RES_STORE;
          end
        end
        RES_STORE: begin
          res[ch] <= res_sat;
          if (ch == 2'd2) begin
            state <= OUTPUT;
          end else begin
            ch    <= ch + 2'd1;
            state <= RES_LO;
          end
        end
        OUTPUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res[2], res[1], res[0]};
            m_tuser  <= status;
            m_tvalid <= 1'b1;
            kcnt     <= 2'd0;
            prev_wl  <= 16'd0;
            for (int i = 0; i < 3; i++) begin
              integ[i]     <= '0;
              prev_prod[i] <= '0;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_error_zero, clk, rst, (m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == '0), "error beat carries nonzero data")
  `ASSERT_ALWAYS(a_rel_y, clk, rst, ($rose(m_tvalid) && m_tuser == STATUS_OK && !absolute_mode) |-> (m_tdata[79:40] == OUT_W'(REL_SCALE)), "relative Y is not 100")
  `ASSERT_NEVER(a_ch_range, clk, rst, ch == 2'd3, "channel index out of range")
  `ASSERT_NEVER(a_kcnt_range, clk, rst, kcnt == 2'd3, "kept count beyond saturation")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the spectral tristimulus integrator core.
`timescale 1ns / 100ps

module testbench;
  import sti_pkg::*;

  typedef struct {
    logic [15:0] wl;
    logic [15:0] val;
    logic [15:0] mx;
    logic [15:0] my;
    logic [15:0] mz;
    logic        is_last;
  } sample_t;

  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic [1:0]       status;
  } tristim_t;

  localparam logic [127:0] PERCENT_Q16 = 128'd6553600;
  localparam int ABS_FRAC_SHIFT = 27;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // wl [15:0], spectral value [31:16], match x [47:32], match y [63:48], match z [79:64]
  logic [79:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // tristim x [39:0], tristim y [79:40], tristim z [119:80]
  logic [119:0] m_tdata;
  // status [1:0]
  logic [1:0] m_tuser;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spectral_tristimulus_integrator_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies and running integration state.
  logic [15:0] win_lo = 16'd0;
  logic [15:0] win_hi = 16'hFFFF;
  logic abs_on = 1'b0;
  logic [23:0] abs_fac = 24'd174848;
  logic [15:0] last_wl = '0;
  logic [63:0] last_prod [3] = '{default: '0};
  int unsigned kept = 0;
  logic [63:0] area [3] = '{default: '0};

  sample_t sample_queue [$];
  tristim_t tristim_due [$];
  int queued_total = 0;
  int mismatches = 0;
  int results_seen = 0;
  int quiet = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_run_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;

  function automatic logic [OUT_W-1:0] clip40(input logic [127:0] v);
    return (v > 128'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  task automatic integrate_sample(input logic [79:0] d, input logic is_last);
    logic [15:0] wl;
    logic [63:0] prod [3];
    logic [64:0] acc;
    logic [127:0] wide;
    tristim_t r;
    wl = d[15:0];
    if (wl >= win_lo && wl <= win_hi) begin
      for (int c = 0; c < 3; c++) prod[c] = 64'(d[31:16]) * 64'(d[32 + 16*c +: 16]);
      if (kept > 0 && wl > last_wl) begin
        for (int c = 0; c < 3; c++) begin
          acc = 65'(area[c]) + 65'(last_prod[c] + prod[c]) * 65'(wl - last_wl);
          area[c] = acc[64] ? '1 : acc[63:0];
        end
      end
      for (int c = 0; c < 3; c++) last_prod[c] = prod[c];
      last_wl = wl;
      if (kept < 65535) kept++;
    end
    if (is_last) begin
      r = '{x: '0, y: '0, z: '0, status: STATUS_OK};
      if (kept < 2) begin
        r.status = STATUS_FEW;
      end else if (area[1] == 0) begin
        r.status = STATUS_ZERO_Y;
      end else if (abs_on) begin
        r.x = clip40((128'(area[0]) * 128'(abs_fac)) >> ABS_FRAC_SHIFT);
        r.y = clip40((128'(area[1]) * 128'(abs_fac)) >> ABS_FRAC_SHIFT);
        r.z = clip40((128'(area[2]) * 128'(abs_fac)) >> ABS_FRAC_SHIFT);
      end else begin
        wide = 128'(area[0]) * PERCENT_Q16 / 128'(area[1]);
        r.x = clip40(wide);
        wide = 128'(area[1]) * PERCENT_Q16 / 128'(area[1]);
        r.y = clip40(wide);
        wide = 128'(area[2]) * PERCENT_Q16 / 128'(area[1]);
        r.z = clip40(wide);
      end
      tristim_due.insert(tristim_due.size(), r);
      last_wl = '0;
      kept = 0;
      for (int c = 0; c < 3; c++) begin
        last_prod[c] = '0;
        area[c] = '0;
      end
    end
  endtask

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (!rst) begin
      if (s_tvalid && s_tready) integrate_sample(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          nxt = sample_queue.pop_front();
          s_tdata <= {nxt.mz, nxt.my, nxt.mx, nxt.val, nxt.wl};
          s_tlast <= nxt.is_last;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: runs of ready and stall, plus one long hold-off on request.
  always @(posedge clk) begin : drive_ready
    bit stall;
    if (!rst) begin
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (rx_run_left == 0) begin
        stall = ($urandom_range(0, 2) == 0);
        rx_run_left <= stall ? $urandom_range(1, 8) : $urandom_range(1, 60);
        m_tready <= !stall;
      end else begin
        rx_run_left <= rx_run_left - 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    tristim_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (tristim_due.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d unexpected: X=%h Y=%h Z=%h status=%0d", results_seen,
                   m_tdata[39:0], m_tdata[79:40], m_tdata[119:80], m_tuser);
        mismatches++;
      end else begin
        e = tristim_due.pop_front();
        if (m_tdata[39:0] !== e.x || m_tdata[79:40] !== e.y || m_tdata[119:80] !== e.z ||
            m_tuser !== e.status) begin
          if (mismatches < 10)
            $display("result %0d: expected X=%h Y=%h Z=%h status=%0d, got X=%h Y=%h Z=%h status=%0d",
                     results_seen, e.x, e.y, e.z, e.status,
                     m_tdata[39:0], m_tdata[79:40], m_tdata[119:80], m_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_write) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[spectral_tristimulus_integrator_core] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic add_sample(input logic [15:0] wl, input logic [15:0] val,
                            input logic [15:0] mx, input logic [15:0] my,
                            input logic [15:0] mz, input logic is_last);
    sample_queue.insert(sample_queue.size(),
                        '{wl: wl, val: val, mx: mx, my: my, mz: mz, is_last: is_last});
    queued_total++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_WINDOW_LOW:  win_lo = v[15:0];
      CFG_WINDOW_HIGH: win_hi = v[15:0];
      CFG_ABS_MODE:    abs_on = v[0];
      default:         abs_fac = v;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sample_queue.size() != 0 || s_tvalid || tristim_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_config();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [23:0] fac;
    case ($urandom_range(0, 5))
      0: begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end
      1: begin
        lo = 16'($urandom_range(400, 65535));
        hi = lo - 16'($urandom_range(1, 300));
      end
      default: begin
        lo = 16'($urandom_range(0, 50000));
        hi = lo + 16'($urandom_range(200, 15000));
      end
    endcase
    case ($urandom_range(0, 3))
      0: fac = 24'hFFFFFF;
      1: fac = 24'($urandom_range(0, 255));
      2: fac = 24'd174848;
      default: fac = 24'($urandom);
    endcase
    write_reg(CFG_WINDOW_LOW, 24'(lo));
    write_reg(CFG_WINDOW_HIGH, 24'(hi));
    write_reg(CFG_ABS_MODE, 24'($urandom_range(0, 1)));
    write_reg(CFG_ABS_FACTOR, fac);
  endtask

  task automatic add_spectrum(input int max_len);
    int len;
    int wl;
    int span;
    bit zero_y;
    logic [15:0] val;
    len = $urandom_range(1, max_len);
    span = (int'(win_hi) - int'(win_lo)) / len;
    if (span < 1) span = 1;
    if (span > 3000) span = 3000;
    wl = int'(win_lo) + int'($urandom_range(0, span)) - 60;
    if (wl < 0) wl = 0;
    zero_y = ($urandom_range(0, 14) == 0);
    for (int i = 0; i < len; i++) begin
      val = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      add_sample(16'(wl), val, 16'($urandom), zero_y ? 16'd0 : 16'($urandom),
                 16'($urandom), i == len - 1);
      if ($urandom_range(0, 19) == 0) wl = wl - int'($urandom_range(0, 5));
      else wl = wl + int'($urandom_range(1, span));
    end
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_sample(16'd1234, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_sample(16'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_sample(16'd200, 16'h8000, 16'h4000, 16'h4000, 16'h1234, 1'b0);
    add_sample(16'd300, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_sample(16'd400, 16'h1234, 16'h5555, 16'h0000, 16'hAAAA, 1'b0);
    add_sample(16'd450, 16'hFFFF, 16'h0001, 16'h0000, 16'h0002, 1'b1);
    add_sample(16'd500, 16'h7000, 16'h3000, 16'h2000, 16'h1000, 1'b0);
    add_sample(16'd500, 16'h7000, 16'h3000, 16'h2000, 16'h1000, 1'b0);
    add_sample(16'd400, 16'h7000, 16'h3000, 16'h2000, 16'h1000, 1'b0);
    add_sample(16'd600, 16'h7000, 16'h3000, 16'h2000, 16'h1000, 1'b1);
    add_sample(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // A tiny Y area against large X and Z areas drives the ratio into saturation.
    add_sample(16'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    add_sample(16'd60000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    add_sample(16'd60001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 1'b1);
    wait_drained();

    write_reg(CFG_ABS_MODE, 24'd1);
    write_reg(CFG_ABS_FACTOR, 24'hFFFFFF);
    add_sample(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    wait_drained();

    write_reg(CFG_ABS_FACTOR, 24'd0);
    add_sample(16'd10, 16'h1234, 16'h2345, 16'h3456, 16'h4567, 1'b0);
    add_sample(16'd20, 16'h5678, 16'h6789, 16'h789A, 16'h89AB, 1'b1);
    wait_drained();

    write_reg(CFG_ABS_MODE, 24'd0);
    write_reg(CFG_WINDOW_LOW, 24'd1000);
    write_reg(CFG_WINDOW_HIGH, 24'd999);
    add_sample(16'd500, 16'hFFFF, 16'h1000, 16'h1000, 16'h1000, 1'b0);
    add_sample(16'd1000, 16'hFFFF, 16'h1000, 16'h1000, 16'h1000, 1'b1);
    wait_drained();

    write_reg(CFG_WINDOW_LOW, 24'd200);
    write_reg(CFG_WINDOW_HIGH, 24'd800);
    add_sample(16'd199, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_sample(16'd200, 16'h4000, 16'h2000, 16'h3000, 16'h1000, 1'b0);
    add_sample(16'd800, 16'h4000, 16'h2000, 16'h3000, 16'h1000, 1'b0);
    add_sample(16'd801, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      random_config();
      // Short spectra while the receiver holds off, so results back up into the input.
      if (ph == 3) hold_req = !hold_req;
      phase_start = queued_total;
      while (queued_total - phase_start < 100) begin
        if ($urandom_range(0, 9) == 0)
          add_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), $urandom_range(0, 7) == 0);
        else
          add_spectrum(ph == 3 ? 3 : 14);
      end
    end

    wait_drained();
    if (mismatches == 0 && tristim_due.size() == 0) begin
      $display("[spectral_tristimulus_integrator_core] OK");
    end else begin
      $display("[spectral_tristimulus_integrator_core] ERROR");
    end
    $finish;
  end

endmodule
